// ===== rtl/core/ogi_pkg.sv =====
// shared types and constants of the occupancy grid inflation unit
package ogi_pkg;

   localparam int CNT_W   = 21;  // item counter
   localparam int IDX_W   = 20;  // emitted raster index
   localparam int GEO_W   = 24;  // frame geometry arithmetic
   localparam int PTR_W   = 12;  // line buffer column pointer, covers the widest map
   localparam int RAD_W   = 4;   // radius register
   localparam int DIM_W   = 11;  // width and height registers
   localparam int RADE_W  = 6;   // clamped radius
   localparam int CSR_A_W = 2;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic [RADE_W-1:0] r;
      logic [DIM_W-1:0]  w;
      logic [GEO_W-1:0]  delay;   // r*w + r
      logic [GEO_W-1:0]  size;    // w*h
      logic [GEO_W-1:0]  end_t;   // size + delay
      logic [GEO_W-1:0]  fin_t;   // size + delay - 1
   } ogi_geom_type;

   // one item as it travels down the row of cells
   typedef struct packed {
      logic             valid;
      logic [PTR_W-1:0] ptr;
      logic             hist_ok;  // a full row of history exists in this frame
      logic             h_valid;  // latest source within the row segment
      logic [7:0]       h_val;
      logic             v_valid;  // latest source over the rows seen so far
      logic [7:0]       v_val;
      logic [7:0]       own;
      logic             emit;
      logic [IDX_W-1:0] idx;
      logic             last;
   } ogi_item_type;

   typedef struct packed {
      logic       v_valid;
      logic [7:0] v_val;
      logic [7:0] own;
   } ogi_line_type;

endpackage

// ===== rtl/core/ogi_front.sv =====
// item counter, horizontal latest-source tracker and own-value delay
module ogi_front #(
   parameter int MAX_RADIUS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic                 in_type,
   input  logic [7:0]           in_value,
   input  ogi_pkg::ogi_geom_type geom,
   output ogi_pkg::ogi_item_type item_o
);
   import ogi_pkg::*;

   localparam int AW  = $clog2(2 * MAX_RADIUS + 2);
   localparam int SAT = 2 * MAX_RADIUS + 1;
   localparam int RW  = $clog2(MAX_RADIUS + 1);

   logic [CNT_W-1:0] t_ff, t_in;
   logic [PTR_W-1:0] col_ff, col_in;
   logic [AW-1:0]    age_ff, age_in;
   logic [7:0]       lval_ff, lval_in;
   logic [7:0]       sh_ff [0:MAX_RADIUS-1];
   logic [7:0]       own_tap [0:MAX_RADIUS];
   ogi_item_type     item_ff, item_in;

   logic [GEO_W-1:0] te;
   logic [7:0]       v;
   logic             src, frame_end, accept;
   logic [AW-1:0]    age_now;

   assign accept = adv && in_valid;
   assign te     = GEO_W'(t_ff);
   assign v      = in_type ? 8'd0 : in_value;

   always_comb begin
      own_tap[0] = v;
      for (int i = 1; i <= MAX_RADIUS; i++) begin
         own_tap[i] = sh_ff[i-1];
      end
   end

   always_comb begin
      src       = (te >= geom.delay) && ((te + geom.delay) < geom.size) && (v != 8'd0);
      frame_end = te >= geom.fin_t;
      if (src) begin
         age_now = '0;
      end else if (age_ff == AW'(SAT)) begin
         age_now = age_ff;
      end else begin
         age_now = age_ff + AW'(1);
      end
      lval_in = src ? v : lval_ff;
      age_in  = frame_end ? AW'(SAT) : age_now;
      t_in    = frame_end ? '0 : t_ff + CNT_W'(1);
      if (frame_end || (col_ff == PTR_W'(geom.w) - PTR_W'(1))) begin
         col_in = '0;
      end else begin
         col_in = col_ff + PTR_W'(1);
      end

      item_in.valid   = in_valid;
      item_in.ptr     = col_ff;
      item_in.hist_ok = te >= GEO_W'(geom.w);
      item_in.h_valid = {1'b0, 8'(age_now)} <= {2'b0, geom.r, 1'b0};
      item_in.h_val   = lval_in;
      item_in.v_valid = item_in.h_valid;
      item_in.v_val   = lval_in;
      item_in.own     = own_tap[geom.r[RW-1:0]];
      item_in.emit    = (te >= geom.delay) && (te < geom.end_t);
      item_in.idx     = IDX_W'(te - geom.delay);
      item_in.last    = te == geom.fin_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff          <= '0;
         col_ff        <= '0;
         age_ff        <= AW'(SAT);
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_in;
         if (accept) begin
            t_ff   <= t_in;
            col_ff <= col_in;
            age_ff <= age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lval_ff  <= lval_in;
         sh_ff[0] <= v;
         for (int i = 1; i < MAX_RADIUS; i++) begin
            sh_ff[i] <= sh_ff[i-1];
         end
      end
   end

   assign item_o = item_ff;

endmodule

// ===== rtl/core/ogi_cell.sv =====
// one row cell: a line buffer one map row long and the newest-row-wins merge
module ogi_cell #(
   parameter int CELL_IDX  = 1,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [ogi_pkg::RADE_W-1:0] r_eff,
   input  ogi_pkg::ogi_item_type item_i,
   output ogi_pkg::ogi_item_type item_o
);
   import ogi_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   ogi_line_type line_mem [0:MAX_WIDTH-1];
   ogi_line_type rd_ff;
   ogi_item_type s1_ff, out_ff, out_in;
   logic         act_v, act_own;

   assign act_v   = 8'(CELL_IDX) <= {1'b0, r_eff, 1'b0};
   assign act_own = 8'(CELL_IDX) <= {2'b0, r_eff};

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= line_mem[item_i.ptr[AW-1:0]];
         if (item_i.valid) begin
            line_mem[item_i.ptr[AW-1:0]] <= '{v_valid: item_i.v_valid,
                                             v_val:   item_i.v_val,
                                             own:     item_i.own};
         end
      end
   end

   always_comb begin
      out_in = s1_ff;
      // the newer row segment wins, older rows only fill in
      if (act_v && !s1_ff.h_valid) begin
         out_in.v_valid = s1_ff.hist_ok && rd_ff.v_valid;
         out_in.v_val   = rd_ff.v_val;
      end else if (act_v) begin
         out_in.v_valid = 1'b1;
         out_in.v_val   = s1_ff.h_val;
      end
      if (act_own) begin
         out_in.own = rd_ff.own;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff  <= item_i;
         out_ff <= out_in;
      end
   end

   assign item_o = out_ff;

endmodule

// ===== rtl/core/occupancy_grid_inflation_unit.sv =====
// occupancy grid inflation: square dilation of a raster occupancy stream
//
// Takes one request per clock while req_tready is high. Cells go in raster order, followed by r*w+r padding
// requests; cell o comes out when request o+r*w+r is taken. A source's latest
// value in raster order wins inside each square of radius r, with linear offsets.
// A result is offered on rsp_tvalid once the request that completes its window
// is taken and has passed the pipeline: a front stage captures the request and
// tracks the latest source within a row segment, 2*MAX_RADIUS cells add two
// stages each, and the output register adds one. Every cell holds one map row in
// its own line buffer (one write and one read port). Line buffer contents are used
// only after this frame wrote them, so there is no clearing pass after reset. The
// input stalls while a result waits in the skid entry behind a blocked output.
// After reset and after each register write, req_tready also stays low while
// the frame geometry settles.
module occupancy_grid_inflation_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] cell_value
   input  logic                          req_tuser,   // [0] req_type
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // [19:0] cell_index, [27:20] out_value
   output logic                          rsp_tlast,   // last_cell
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ogi_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [ogi_pkg::DIM_W-1:0]     csr_data
);
   import ogi_pkg::*;

   localparam int NC = 2 * MAX_RADIUS;

   logic [RAD_W-1:0]  radius_ff;
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [RADE_W-1:0] r_q_ff, r_c;
   logic [DIM_W-1:0]  w_q_ff, w_c, h_c;
   logic [21:0]       size_q_ff, rw_q_ff;
   ogi_geom_type      geom_ff, geom_in;
   logic [1:0]        cfg_hold_ff;
   logic              in_open, req_take;

   ogi_item_type chain [0:NC];
   logic         adv;

   logic              out_valid_ff, skid_valid_ff;
   logic [IDX_W-1:0]  out_idx_ff, skid_idx_ff;
   logic [7:0]        out_val_ff, skid_val_ff;
   logic              out_last_ff, skid_last_ff;
   logic              new_rsp;
   logic [7:0]        new_val;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(3);
         width_ff  <= DIM_W'(1024);
         height_ff <= DIM_W'(1024);
      end else if (csr_valid) begin
         case (csr_addr_type'(csr_index))
            CSR_RADIUS: radius_ff <= csr_data[RAD_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // after a register changes, geometry passes through the *_q_ff registers before it reaches geom_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_hold_ff <= 2'd2;
      end else if (csr_valid && csr_ready) begin
         cfg_hold_ff <= 2'd2;
      end else if (cfg_hold_ff != 2'd0) begin
         cfg_hold_ff <= cfg_hold_ff - 2'd1;
      end
   end

   // clamp registers into range, then build the frame geometry
   always_comb begin
      r_c = ({4'b0, radius_ff} > 8'(MAX_RADIUS)) ? RADE_W'(MAX_RADIUS)
                                                 : RADE_W'(radius_ff);
      if (width_ff == '0) begin
         w_c = DIM_W'(1);
      end else if ({2'b0, width_ff} > 13'(MAX_WIDTH)) begin
         w_c = DIM_W'(MAX_WIDTH);
      end else begin
         w_c = width_ff;
      end
      if (height_ff == '0) begin
         h_c = DIM_W'(1);
      end else if ({2'b0, height_ff} > 13'(MAX_HEIGHT)) begin
         h_c = DIM_W'(MAX_HEIGHT);
      end else begin
         h_c = height_ff;
      end
      geom_in.r     = r_q_ff;
      geom_in.w     = w_q_ff;
      geom_in.size  = GEO_W'(size_q_ff);
      geom_in.delay = GEO_W'(rw_q_ff) + GEO_W'(r_q_ff);
      geom_in.end_t = GEO_W'(size_q_ff) + GEO_W'(rw_q_ff) + GEO_W'(r_q_ff);
      geom_in.fin_t = geom_in.end_t - GEO_W'(1);
   end

   always_ff @(posedge clock) begin
      r_q_ff    <= r_c;
      w_q_ff    <= w_c;
      size_q_ff <= 22'(w_c * h_c);
      rw_q_ff   <= 22'(r_c * w_c);
      geom_ff   <= geom_in;
   end

   assign adv        = !skid_valid_ff;
   assign in_open    = (cfg_hold_ff == 2'd0);
   assign req_take   = req_tvalid && in_open;
   assign req_tready = adv && in_open;

   ogi_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_take),
      .in_type  (req_tuser),
      .in_value (req_tdata),
      .geom     (geom_ff),
      .item_o   (chain[0])
   );

   for (genvar c = 1; c <= NC; c++) begin : g_cell
      ogi_cell #(
         .CELL_IDX  (c),
         .MAX_WIDTH (MAX_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .r_eff  (geom_ff.r),
         .item_i (chain[c-1]),
         .item_o (chain[c])
      );
   end

   assign new_rsp = adv && chain[NC].valid && chain[NC].emit;
   assign new_val = chain[NC].v_valid ? chain[NC].v_val : chain[NC].own;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_idx_ff    <= skid_idx_ff;
            out_val_ff    <= skid_val_ff;
            out_last_ff   <= skid_last_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= new_rsp;
         out_idx_ff   <= chain[NC].idx;
         out_val_ff   <= new_val;
         out_last_ff  <= chain[NC].last;
      end else if (new_rsp) begin
         skid_valid_ff <= 1'b1;
         skid_idx_ff   <= chain[NC].idx;
         skid_val_ff   <= new_val;
         skid_last_ff  <= chain[NC].last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_val_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid filled while the output could move");

   a_last_emitted: assert property (@(posedge clock) disable iff (reset)
      (chain[0].valid && chain[0].last) |-> chain[0].emit)
      else $error("final cell marked on a request that emits nothing");

endmodule
